>>> src/integer_literal_parser_assert.svh
// assertion macros for the integer literal parser
`ifndef INTEGER_LITERAL_PARSER_ASSERT_SVH
`define INTEGER_LITERAL_PARSER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ILP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("integer_literal_parser: same-cycle check failed");

// next-cycle implication, checked outside reset
`define ILP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("integer_literal_parser: next-cycle check failed");

`endif

>>> src/ilp_pkg.sv
// shared types, phase codes and character helpers for the integer literal parser
package ilp_pkg;

   localparam int CHAR_W  = 8;
   localparam int VALUE_W = 32;

   typedef logic [CHAR_W-1:0]  char_type;
   typedef logic [VALUE_W-1:0] value_type;
   typedef logic [2:0]         phase_type;

   // parser phases
   localparam phase_type PH_LEAD     = 3'd0;
   localparam phase_type PH_SIGN     = 3'd1;
   localparam phase_type PH_ZERO     = 3'd2;
   localparam phase_type PH_HEXSTART = 3'd3;
   localparam phase_type PH_HEX      = 3'd4;
   localparam phase_type PH_OCT      = 3'd5;
   localparam phase_type PH_DEC      = 3'd6;
   localparam phase_type PH_TRAIL    = 3'd7;

   localparam char_type CHAR_TAB   = 8'h09;
   localparam char_type CHAR_SPACE = 8'h20;
   localparam char_type CHAR_PLUS  = 8'h2b;
   localparam char_type CHAR_MINUS = 8'h2d;
   localparam char_type CHAR_0     = 8'h30;
   localparam char_type CHAR_1     = 8'h31;
   localparam char_type CHAR_7     = 8'h37;
   localparam char_type CHAR_9     = 8'h39;
   localparam char_type CHAR_UA    = 8'h41;
   localparam char_type CHAR_UF    = 8'h46;
   localparam char_type CHAR_UX    = 8'h58;
   localparam char_type CHAR_LA    = 8'h61;
   localparam char_type CHAR_LF    = 8'h66;
   localparam char_type CHAR_LX    = 8'h78;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_digit_type;

   function automatic logic is_blank(input char_type c);
      return (c == CHAR_SPACE) || (c == CHAR_TAB);
   endfunction

   function automatic hex_digit_type hex_digit(input char_type c);
      hex_digit_type h;
      h.ok    = 1'b1;
      h.value = c[3:0];
      if (c >= CHAR_0 && c <= CHAR_9) begin
         h.value = c[3:0];
      end else if ((c >= CHAR_LA && c <= CHAR_LF) || (c >= CHAR_UA && c <= CHAR_UF)) begin
         // 'a' and 'A' both have low nibble 1
         h.value = c[3:0] + 4'd9;
      end else begin
         h.ok = 1'b0;
      end
      return h;
   endfunction

endpackage

>>> src/integer_literal_parser.sv
// result path: a field's last character is held in the input register, and its result is then
// registered in the result register and shown on rsp
// throughput: one character per cycle; input register, one step of logic, result register
// the step is a constant multiply-add on the 32-bit accumulator (shifts, two adds for decimal)
// a result held by rsp_tready low stalls the input register; an empty input register still loads
// reset: synchronous, active high; clears the parser to the leading-blank phase and empties both
`include "integer_literal_parser_assert.svh"

module integer_literal_parser
   import ilp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_char
   input  logic        req_tlast,   // is_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] number
   output logic [0:0]  rsp_tuser    // [0] valid_res
);

   // input register
   logic      s1_valid_ff, s1_valid_in;
   char_type  s1_char_ff;
   logic      s1_last_ff;

   // parser state
   phase_type phase_ff, phase_in;
   value_type acc_ff, acc_in;
   logic      neg_ff, neg_in;
   logic      failed_ff, failed_in;

   // result register
   logic      out_valid_ff, out_valid_in;
   value_type out_number_ff, out_number_in;
   logic      out_ok_ff, out_ok_in;

   logic      advance;
   logic      fail;
   logic      is_digit, is_octal, blank;
   hex_digit_type hd;
   phase_type step_phase;
   value_type step_acc;
   logic      step_neg;
   logic      step_failed;
   logic      ok_end;
   value_type signed_val;

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;

   assign is_digit = (s1_char_ff >= CHAR_0) && (s1_char_ff <= CHAR_9);
   assign is_octal = (s1_char_ff >= CHAR_0) && (s1_char_ff <= CHAR_7);
   assign blank    = is_blank(s1_char_ff);
   assign hd       = hex_digit(s1_char_ff);

   always_comb begin
      step_phase = phase_ff;
      step_acc   = acc_ff;
      step_neg   = neg_ff;
      fail       = 1'b0;
      if (!failed_ff) begin
         unique case (phase_ff) inside
            PH_LEAD, PH_SIGN: begin
               if (phase_ff == PH_LEAD && blank) begin
                  step_phase = PH_LEAD;
               end else if (phase_ff == PH_LEAD && s1_char_ff == CHAR_MINUS) begin
                  step_neg   = 1'b1;
                  step_phase = PH_SIGN;
               end else if (phase_ff == PH_LEAD && s1_char_ff == CHAR_PLUS) begin
                  step_phase = PH_SIGN;
               end else if (s1_char_ff == CHAR_0) begin
                  step_phase = PH_ZERO;
               end else if (s1_char_ff >= CHAR_1 && s1_char_ff <= CHAR_9) begin
                  step_acc   = {{(VALUE_W-4){1'b0}}, s1_char_ff[3:0]};
                  step_phase = PH_DEC;
               end else begin
                  fail = 1'b1;
               end
            end
            PH_ZERO: begin
               if (s1_char_ff == CHAR_LX || s1_char_ff == CHAR_UX) begin
                  step_phase = PH_HEXSTART;
               end else if (is_octal) begin
                  step_acc   = {{(VALUE_W-4){1'b0}}, s1_char_ff[3:0]};
                  step_phase = PH_OCT;
               end else if (blank) begin
                  step_phase = PH_TRAIL;
               end else begin
                  fail = 1'b1;
               end
            end
            PH_HEXSTART, PH_HEX: begin
               if (hd.ok) begin
                  step_acc   = {acc_ff[VALUE_W-5:0], hd.value};
                  step_phase = PH_HEX;
               end else if (phase_ff == PH_HEX && blank) begin
                  step_phase = PH_TRAIL;
               end else begin
                  fail = 1'b1;
               end
            end
            PH_OCT: begin
               if (is_octal) begin
                  step_acc = {acc_ff[VALUE_W-4:0], s1_char_ff[2:0]};
               end else if (blank) begin
                  step_phase = PH_TRAIL;
               end else begin
                  fail = 1'b1;
               end
            end
            PH_DEC: begin
               if (is_digit) begin
                  // times ten as eight plus two
                  step_acc = {acc_ff[VALUE_W-4:0], 3'b000} + {acc_ff[VALUE_W-2:0], 1'b0}
                           + {{(VALUE_W-4){1'b0}}, s1_char_ff[3:0]};
               end else if (blank) begin
                  step_phase = PH_TRAIL;
               end else begin
                  fail = 1'b1;
               end
            end
            default: begin
               // trailing blanks only
               if (!blank) begin
                  fail = 1'b1;
               end
            end
         endcase
      end
      step_failed = failed_ff || fail;
   end

   assign ok_end = !step_failed && (step_phase == PH_ZERO || step_phase == PH_HEX ||
                                    step_phase == PH_OCT  || step_phase == PH_DEC ||
                                    step_phase == PH_TRAIL);
   assign signed_val = step_neg ? (~step_acc + value_type'(1)) : step_acc;

   always_comb begin
      s1_valid_in   = s1_valid_ff;
      phase_in      = phase_ff;
      acc_in        = acc_ff;
      neg_in        = neg_ff;
      failed_in     = failed_ff;
      out_valid_in  = out_valid_ff;
      out_number_in = out_number_ff;
      out_ok_in     = out_ok_ff;
      // the input register loads whenever it is free or moving on
      if (req_tready) begin
         s1_valid_in = req_tvalid;
      end
      if (advance) begin
         out_valid_in = s1_valid_ff && s1_last_ff;
         if (s1_valid_ff) begin
            if (s1_last_ff) begin
               out_number_in = ok_end ? signed_val : '0;
               out_ok_in     = ok_end;
               phase_in      = PH_LEAD;
               acc_in        = '0;
               neg_in        = 1'b0;
               failed_in     = 1'b0;
            end else begin
               phase_in  = step_phase;
               acc_in    = step_acc;
               neg_in    = step_neg;
               failed_in = step_failed;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         phase_ff     <= PH_LEAD;
         acc_ff       <= '0;
         neg_ff       <= 1'b0;
         failed_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         phase_ff     <= phase_in;
         acc_ff       <= acc_in;
         neg_ff       <= neg_in;
         failed_ff    <= failed_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         s1_char_ff <= req_tdata;
         s1_last_ff <= req_tlast;
      end
      out_number_ff <= out_number_in;
      out_ok_ff     <= out_ok_in;
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = out_number_ff;
   assign rsp_tuser[0] = out_ok_ff;

   // a last character that moves on always leaves a result and a cleared parser
   `ILP_ASSERT_NEXT(a_last_gives_result, clock, reset,
      advance && s1_valid_ff && s1_last_ff, out_valid_ff && phase_ff == PH_LEAD)
   `ILP_ASSERT_NEXT(a_last_clears_state, clock, reset,
      advance && s1_valid_ff && s1_last_ff, acc_ff == '0 && !neg_ff && !failed_ff)
   // nothing builds up while still in leading blanks
   `ILP_ASSERT_NOW(a_lead_is_clean, clock, reset,
      phase_ff == PH_LEAD, acc_ff == '0 && !neg_ff)
   // a held input register never takes a new transfer
   `ILP_ASSERT_NOW(a_no_overrun, clock, reset,
      s1_valid_ff && !advance, !req_tready)

endmodule

>>> verif/testbench.sv
// self-checking testbench for the integer literal parser: directed fields, then random fields
module testbench;
   import ilp_pkg::*;

   typedef struct packed {
      value_type number;
      logic      valid_res;
   } literal_result_type;

   // one directed field: text right-justified, first character in the highest used byte
   typedef struct packed {
      logic [39:0] text;
      logic [3:0]  len;
      logic        typed;
      value_type   number;
      logic        valid_res;
   } probe_row_type;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASE_CHARS    = 170;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [0:0]  rsp_tuser;

   // predictor state
   phase_type lit_phase  = PH_LEAD;
   value_type lit_acc    = '0;
   logic      lit_neg    = 1'b0;
   logic      lit_failed = 1'b0;

   literal_result_type pending_literals[$];
   literal_result_type head_result;
   char_type           field_chars[$];

   int sender_idle_pct   = 11;
   int receiver_idle_pct = 59;
   int chars_sent        = 0;
   int failures          = 0;
   int idle_cycles       = 0;

   probe_row_type probes [13] = '{
      '{" ",       4'd1, 1'b1, 32'd0,        1'b0},  // blanks only
      '{"-",       4'd1, 1'b1, 32'd0,        1'b0},  // lone sign
      '{"+ ",      4'd2, 1'b1, 32'd0,        1'b0},  // sign then blank
      '{"0",       4'd1, 1'b1, 32'd0,        1'b1},
      '{"\t9 ",    4'd3, 1'b1, 32'd9,        1'b1},
      '{"1 2",     4'd3, 1'b1, 32'd0,        1'b0},  // blank inside the digits
      '{"0x",      4'd2, 1'b1, 32'd0,        1'b0},  // hex prefix with no digit
      '{"08",      4'd2, 1'b1, 32'd0,        1'b0},  // non-octal digit
      '{"\r",      4'd1, 1'b1, 32'd0,        1'b0},
      '{40'h00,    4'd1, 1'b1, 32'd0,        1'b0},
      '{40'hff,    4'd1, 1'b1, 32'd0,        1'b0},
      '{"-0XaF",   4'd5, 1'b1, 32'hffffff51, 1'b1},
      '{"017",     4'd3, 1'b0, 32'd0,        1'b0}
   };

   integer_literal_parser DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // advance the parse state by one character
   function automatic void absorb_char(input char_type c);
      logic       blank;
      logic       dec;
      logic       hexd;
      logic       fail;
      logic [3:0] nib;
      blank = (c == CHAR_SPACE) || (c == CHAR_TAB);
      dec   = (c >= CHAR_0) && (c <= CHAR_9);
      hexd  = 1'b1;
      nib   = 4'd0;
      if (dec) begin
         nib = 4'(c - CHAR_0);
      end else if (c >= CHAR_LA && c <= CHAR_LF) begin
         nib = 4'(c - CHAR_LA + 8'd10);
      end else if (c >= CHAR_UA && c <= CHAR_UF) begin
         nib = 4'(c - CHAR_UA + 8'd10);
      end else begin
         hexd = 1'b0;
      end
      if (lit_failed) return;
      fail = 1'b1;
      case (lit_phase)
         PH_LEAD, PH_SIGN: begin
            if (lit_phase == PH_LEAD && blank) begin
               fail = 1'b0;
            end else if (lit_phase == PH_LEAD && (c == CHAR_MINUS || c == CHAR_PLUS)) begin
               lit_neg   = (c == CHAR_MINUS);
               lit_phase = PH_SIGN;
               fail      = 1'b0;
            end else if (c == CHAR_0) begin
               lit_phase = PH_ZERO;
               fail      = 1'b0;
            end else if (dec) begin
               lit_acc   = value_type'(nib);
               lit_phase = PH_DEC;
               fail      = 1'b0;
            end
         end
         PH_ZERO: begin
            if (c == CHAR_LX || c == CHAR_UX) begin
               lit_phase = PH_HEXSTART;
               fail      = 1'b0;
            end else if (c >= CHAR_0 && c <= CHAR_7) begin
               lit_acc   = value_type'(nib);
               lit_phase = PH_OCT;
               fail      = 1'b0;
            end else if (blank) begin
               lit_phase = PH_TRAIL;
               fail      = 1'b0;
            end
         end
         PH_HEXSTART, PH_HEX: begin
            if (hexd) begin
               lit_acc   = lit_acc * 16 + value_type'(nib);
               lit_phase = PH_HEX;
               fail      = 1'b0;
            end else if (lit_phase == PH_HEX && blank) begin
               lit_phase = PH_TRAIL;
               fail      = 1'b0;
            end
         end
         PH_OCT: begin
            if (c >= CHAR_0 && c <= CHAR_7) begin
               lit_acc = lit_acc * 8 + value_type'(nib);
               fail    = 1'b0;
            end else if (blank) begin
               lit_phase = PH_TRAIL;
               fail      = 1'b0;
            end
         end
         PH_DEC: begin
            if (dec) begin
               lit_acc = lit_acc * 10 + value_type'(nib);
               fail    = 1'b0;
            end else if (blank) begin
               lit_phase = PH_TRAIL;
               fail      = 1'b0;
            end
         end
         default: begin
            if (blank) fail = 1'b0;
         end
      endcase
      if (fail) lit_failed = 1'b1;
   endfunction

   // hand one character over, then predict; a typed result replaces the prediction
   task automatic send_char(input char_type c, input logic last, input logic typed,
                            input literal_result_type typed_res);
      literal_result_type r;
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      absorb_char(c);
      if (last) begin
         r.valid_res = !lit_failed &&
                       (lit_phase inside {PH_ZERO, PH_HEX, PH_OCT, PH_DEC, PH_TRAIL});
         r.number    = r.valid_res ? (lit_neg ? -lit_acc : lit_acc) : '0;
         pending_literals.push_back(typed ? typed_res : r);
         lit_phase  = PH_LEAD;
         lit_acc    = '0;
         lit_neg    = 1'b0;
         lit_failed = 1'b0;
      end
      chars_sent++;
   endtask

   function automatic char_type pick_blank();
      return ($urandom_range(0, 1) != 0) ? CHAR_SPACE : CHAR_TAB;
   endfunction

   // mostly well-formed literals with random content, some corrupted, some pure noise
   task automatic build_field();
      int kind;
      int n;
      int pos;
      field_chars.delete();
      repeat ($urandom_range(0, 2)) field_chars.push_back(pick_blank());
      kind = $urandom_range(0, 9);
      if (kind == 9) begin
         repeat ($urandom_range(1, 4)) field_chars.push_back(char_type'($urandom_range(0, 255)));
      end else begin
         case ($urandom_range(0, 3))
            0: field_chars.push_back(CHAR_MINUS);
            1: field_chars.push_back(CHAR_PLUS);
            default: ;
         endcase
         case ($urandom_range(0, 3))
            0: begin
               field_chars.push_back(char_type'(CHAR_1 + $urandom_range(0, 8)));
               repeat ($urandom_range(0, 9))
                  field_chars.push_back(char_type'(CHAR_0 + $urandom_range(0, 9)));
            end
            1: begin
               field_chars.push_back(CHAR_0);
               field_chars.push_back(($urandom_range(0, 1) != 0) ? CHAR_LX : CHAR_UX);
               repeat ($urandom_range(1, 9)) begin
                  n = $urandom_range(0, 15);
                  if (n < 10) field_chars.push_back(char_type'(CHAR_0 + n));
                  else if ($urandom_range(0, 1) != 0)
                     field_chars.push_back(char_type'(CHAR_LA + n - 10));
                  else field_chars.push_back(char_type'(CHAR_UA + n - 10));
               end
            end
            2: begin
               field_chars.push_back(CHAR_0);
               repeat ($urandom_range(1, 11))
                  field_chars.push_back(char_type'(CHAR_0 + $urandom_range(0, 7)));
            end
            default: field_chars.push_back(CHAR_0);
         endcase
         repeat ($urandom_range(0, 2)) field_chars.push_back(pick_blank());
         if (kind == 8) begin
            pos = $urandom_range(0, field_chars.size() - 1);
            field_chars[pos] = ($urandom_range(0, 1) != 0) ? pick_blank()
                                                           : char_type'($urandom_range(0, 255));
         end
      end
   endtask

   initial begin
      int target;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      foreach (probes[i]) begin
         for (int k = 0; k < probes[i].len; k++) begin
            send_char(probes[i].text[8*(probes[i].len-1-k) +: 8], k == probes[i].len - 1,
                      probes[i].typed,
                      literal_result_type'{probes[i].number, probes[i].valid_res});
         end
      end
      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin sender_idle_pct = 11; receiver_idle_pct = 59; end
            1: begin sender_idle_pct = 59; receiver_idle_pct = 11; end
            default: begin sender_idle_pct = 0; receiver_idle_pct = 0; end
         endcase
         target = chars_sent + PHASE_CHARS;
         while (chars_sent < target) begin
            build_field();
            foreach (field_chars[j])
               send_char(field_chars[j], j == field_chars.size() - 1, 1'b0, '0);
         end
         // hold off until every result of this phase has drained
         req_tvalid <= 1'b0;
         do @(posedge clock); while (pending_literals.size() != 0);
      end
      repeat (8) @(posedge clock);
      if (failures == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

   // result side: random back-pressure and comparison with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_literals.size() == 0) begin
            failures++;
            $display("%0t: unexpected result, expected none, got number %h valid %b",
                     $time, rsp_tdata, rsp_tuser[0]);
         end else begin
            head_result = pending_literals.pop_front();
            if (rsp_tdata !== head_result.number) begin
               failures++;
               $display("%0t: number mismatch, expected %h, got %h",
                        $time, head_result.number, rsp_tdata);
            end
            if (rsp_tuser[0] !== head_result.valid_res) begin
               failures++;
               $display("%0t: valid flag mismatch, expected %b, got %b",
                        $time, head_result.valid_res, rsp_tuser[0]);
            end
         end
      end
      rsp_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
         end
      end
   end

endmodule
